[src/mosl_pkg.sv]
// Shared constants, codes and payload types for the median of two sorted lists.
package mosl_pkg;

  localparam int unsigned LIST_DEPTH = 256;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned RES_W      = DATA_W + 1;
  localparam int unsigned IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int unsigned K_W        = $clog2(2 * LIST_DEPTH + 1);

  localparam logic [1:0] MODE_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] MODE_LOAD_SECOND = 2'd1;
  localparam logic [1:0] MODE_COMPUTE     = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [RES_W-1:0] median_doubled;
    logic [1:0]              status;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] first_count;
    logic [CNT_W-1:0] second_count;
    logic             overflow;
  } job_t;

endpackage

[src/mosl_store.sv]
// One list store: synchronous memory with one write port and one registered read port.
module mosl_store (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [mosl_pkg::IDX_W-1:0]  waddr_i,
  input  logic [mosl_pkg::DATA_W-1:0] wdata_i,
  input  logic [mosl_pkg::IDX_W-1:0]  raddr_i,
  output logic [mosl_pkg::DATA_W-1:0] rdata_o
);

  logic [mosl_pkg::DATA_W-1:0] mem_q [mosl_pkg::LIST_DEPTH];
  logic [mosl_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/mosl_ctrl.sv]
// Selection sequencer: runs the halving k-th smallest search over both stores.
module mosl_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  mosl_pkg::job_t              job_i,
  output logic                        idle_o,
  output logic                        done_valid_o,
  input  logic                        done_ready_i,
  output mosl_pkg::out_item_t         result_o,
  output logic [mosl_pkg::IDX_W-1:0]  raddr0_o,
  output logic [mosl_pkg::IDX_W-1:0]  raddr1_o,
  input  logic [mosl_pkg::DATA_W-1:0] rdata0_i,
  input  logic [mosl_pkg::DATA_W-1:0] rdata1_i
);

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_EVAL, ST_DONE} state_e;
  typedef enum logic [1:0] {KIND_TAIL, KIND_MIN, KIND_STEP} kind_e;

  localparam int unsigned CW = mosl_pkg::CNT_W;
  localparam int unsigned KW = mosl_pkg::K_W;
  localparam int unsigned DW = mosl_pkg::DATA_W;
  localparam int unsigned RW = mosl_pkg::RES_W;

  state_e              state_q;
  kind_e               kind_q;
  logic                sel_q;
  logic [CW-1:0]       sta_q, sza_q, stb_q, szb_q, p1_q, p2_q;
  logic [CW-1:0]       first_cnt_q, second_cnt_q;
  logic [KW-1:0]       k_q, kmid_q;
  logic                even_q, second_pass_q;
  logic signed [DW-1:0] acc_q;
  mosl_pkg::out_item_t res_q;

  // Issue stage: normalize so that list a is the shorter one, then form addresses.
  logic          swap, a_sel;
  logic [CW-1:0] ca_st, ca_sz, cb_st, cb_sz, p1, p2;
  logic [KW-1:0] half_k, rem_k, addr_a_w, addr_b_w, total;
  kind_e         kind;

  always_comb begin
    swap  = sza_q > szb_q;
    a_sel = sel_q ^ swap;
    ca_st = swap ? stb_q : sta_q;
    ca_sz = swap ? szb_q : sza_q;
    cb_st = swap ? sta_q : stb_q;
    cb_sz = swap ? sza_q : szb_q;
    half_k = k_q >> 1;
    p1     = (half_k > KW'(ca_sz)) ? ca_sz : half_k[CW-1:0];
    rem_k  = k_q - KW'(p1);
    p2     = (rem_k > KW'(cb_sz)) ? cb_sz : rem_k[CW-1:0];
    if (ca_sz == '0) begin
      kind     = KIND_TAIL;
      addr_a_w = KW'(ca_st);
      addr_b_w = KW'(cb_st) + k_q - KW'(1);
    end else if (k_q == KW'(1)) begin
      kind     = KIND_MIN;
      addr_a_w = KW'(ca_st);
      addr_b_w = KW'(cb_st);
    end else begin
      kind     = KIND_STEP;
      addr_a_w = KW'(ca_st) + KW'(p1) - KW'(1);
      addr_b_w = KW'(cb_st) + KW'(p2) - KW'(1);
    end
    total = KW'(job_i.first_count) + KW'(job_i.second_count);
  end

  assign raddr0_o = a_sel ? addr_b_w[mosl_pkg::IDX_W-1:0] : addr_a_w[mosl_pkg::IDX_W-1:0];
  assign raddr1_o = a_sel ? addr_a_w[mosl_pkg::IDX_W-1:0] : addr_b_w[mosl_pkg::IDX_W-1:0];

  // Evaluate stage: read data arrives in the cycle after issue.
  logic signed [DW-1:0] x, y, pick;
  logic                 sel_done, a_greater;
  logic signed [RW-1:0] combined;

  always_comb begin
    x         = sel_q ? $signed(rdata1_i) : $signed(rdata0_i);
    y         = sel_q ? $signed(rdata0_i) : $signed(rdata1_i);
    a_greater = x > y;
    sel_done  = 1'b0;
    pick      = y;
    case (kind_q)
      KIND_TAIL: begin
        sel_done = 1'b1;
        pick     = y;
      end
      KIND_MIN: begin
        sel_done = 1'b1;
        pick     = a_greater ? y : x;
      end
      default: begin
        sel_done = 1'b0;
        pick     = y;
      end
    endcase
    if (even_q) begin
      combined = {acc_q[DW-1], acc_q} + {pick[DW-1], pick};
    end else begin
      combined = {pick, 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      kind_q        <= KIND_TAIL;
      sel_q         <= 1'b0;
      sta_q         <= '0;
      sza_q         <= '0;
      stb_q         <= '0;
      szb_q         <= '0;
      p1_q          <= '0;
      p2_q          <= '0;
      first_cnt_q   <= '0;
      second_cnt_q  <= '0;
      k_q           <= '0;
      kmid_q        <= '0;
      even_q        <= 1'b0;
      second_pass_q <= 1'b0;
      acc_q         <= '0;
      res_q         <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            first_cnt_q   <= job_i.first_count;
            second_cnt_q  <= job_i.second_count;
            sel_q         <= 1'b0;
            sta_q         <= '0;
            sza_q         <= job_i.first_count;
            stb_q         <= '0;
            szb_q         <= job_i.second_count;
            second_pass_q <= 1'b0;
            even_q        <= !total[0];
            kmid_q        <= (total >> 1) + KW'(1);
            k_q           <= total[0] ? (total >> 1) + KW'(1) : (total >> 1);
            if (total == '0) begin
              res_q.median_doubled <= '0;
              res_q.status         <= mosl_pkg::STATUS_EMPTY;
              state_q              <= ST_DONE;
            end else begin
              res_q.status <= job_i.overflow ? mosl_pkg::STATUS_OVERFLOW
                                             : mosl_pkg::STATUS_OK;
              state_q      <= ST_ISSUE;
            end
          end
        end
        ST_ISSUE: begin
          sel_q   <= a_sel;
          sta_q   <= ca_st;
          sza_q   <= ca_sz;
          stb_q   <= cb_st;
          szb_q   <= cb_sz;
          kind_q  <= kind;
          p1_q    <= p1;
          p2_q    <= p2;
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          if (sel_done) begin
            if (even_q && !second_pass_q) begin
              // First of the two middle elements found; restart for the upper one.
              acc_q         <= pick;
              second_pass_q <= 1'b1;
              sel_q         <= 1'b0;
              sta_q         <= '0;
              sza_q         <= first_cnt_q;
              stb_q         <= '0;
              szb_q         <= second_cnt_q;
              k_q           <= kmid_q;
              state_q       <= ST_ISSUE;
            end else begin
              res_q.median_doubled <= combined;
              state_q              <= ST_DONE;
            end
          end else begin
            if (a_greater) begin
              stb_q <= stb_q + p2_q;
              szb_q <= szb_q - p2_q;
              k_q   <= k_q - KW'(p2_q);
              sza_q <= p1_q;
            end else begin
              sta_q <= sta_q + p1_q;
              sza_q <= sza_q - p1_q;
              k_q   <= k_q - KW'(p1_q);
            end
            state_q <= ST_ISSUE;
          end
        end
        ST_DONE: begin
          if (done_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign idle_o       = state_q == ST_IDLE;
  assign done_valid_o = state_q == ST_DONE;
  assign result_o     = res_q;

endmodule

[src/median_of_two_sorted_lists.sv]
// Load items are accepted back to back, one per cycle, while the sequencer is idle; a dropped
// load is accepted the same way. Each halving step of a compute is one store read and one
// compare; a compute runs one selection for an odd total and two for an even one, then posts
// its result. A compute with both lists empty runs no halving step. No item is taken during a
// compute, nor while its finished result waits for the output register to drain.
// Reset clears the list counts, the overflow flag and all control; store contents stay unset.
module median_of_two_sorted_lists (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mosl_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mosl_pkg::out_item_t out_data_o
);

  localparam int unsigned CW = mosl_pkg::CNT_W;

  logic [CW-1:0]       first_count_q, first_count_d, second_count_q, second_count_d;
  logic                overflow_q, overflow_d;
  logic                out_valid_q;
  mosl_pkg::out_item_t out_data_q;

  logic                accept, compute, we_first, we_second;
  logic                first_full, second_full;
  logic                ctrl_idle, done_valid, done_ready;
  mosl_pkg::job_t      job;
  mosl_pkg::out_item_t result;
  logic [mosl_pkg::IDX_W-1:0]  raddr0, raddr1;
  logic [mosl_pkg::DATA_W-1:0] rdata0, rdata1;

  assign accept      = in_valid_i && in_ready_o;
  assign first_full  = first_count_q >= CW'(mosl_pkg::LIST_DEPTH);
  assign second_full = second_count_q >= CW'(mosl_pkg::LIST_DEPTH);
  assign we_first    = accept && (in_data_i.mode == mosl_pkg::MODE_LOAD_FIRST) && !first_full;
  assign we_second   = accept && (in_data_i.mode == mosl_pkg::MODE_LOAD_SECOND) && !second_full;
  assign compute     = accept && (in_data_i.mode == mosl_pkg::MODE_COMPUTE);

  always_comb begin
    first_count_d  = first_count_q;
    second_count_d = second_count_q;
    overflow_d     = overflow_q;
    if (compute) begin
      first_count_d  = '0;
      second_count_d = '0;
      overflow_d     = 1'b0;
    end else if (accept) begin
      case (in_data_i.mode)
        mosl_pkg::MODE_LOAD_FIRST: begin
          if (first_full) begin
            overflow_d = 1'b1;
          end else begin
            first_count_d = first_count_q + CW'(1);
          end
        end
        mosl_pkg::MODE_LOAD_SECOND: begin
          if (second_full) begin
            overflow_d = 1'b1;
          end else begin
            second_count_d = second_count_q + CW'(1);
          end
        end
        default: begin
          overflow_d = overflow_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_count_q  <= '0;
      second_count_q <= '0;
      overflow_q     <= 1'b0;
    end else begin
      first_count_q  <= first_count_d;
      second_count_q <= second_count_d;
      overflow_q     <= overflow_d;
    end
  end

  // Stores are written only while the sequencer is idle, so reads never race a write.
  mosl_store u_first_store (
    .clk_i   (clk_i),
    .we_i    (we_first),
    .waddr_i (first_count_q[mosl_pkg::IDX_W-1:0]),
    .wdata_i (in_data_i.value),
    .raddr_i (raddr0),
    .rdata_o (rdata0)
  );

  mosl_store u_second_store (
    .clk_i   (clk_i),
    .we_i    (we_second),
    .waddr_i (second_count_q[mosl_pkg::IDX_W-1:0]),
    .wdata_i (in_data_i.value),
    .raddr_i (raddr1),
    .rdata_o (rdata1)
  );

  assign job.first_count  = first_count_q;
  assign job.second_count = second_count_q;
  assign job.overflow     = overflow_q;

  mosl_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (compute),
    .job_i        (job),
    .idle_o       (ctrl_idle),
    .done_valid_o (done_valid),
    .done_ready_i (done_ready),
    .result_o     (result),
    .raddr0_o     (raddr0),
    .raddr1_o     (raddr1),
    .rdata0_i     (rdata0),
    .rdata1_i     (rdata1)
  );

  // Output register: a finished result waits here while loads keep flowing.
  assign done_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done_valid && done_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_valid && done_ready) begin
      out_data_q <= result;
    end
  end

  assign in_ready_o  = ctrl_idle;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_compute_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    compute |=> (first_count_q == '0) && (second_count_q == '0) && !overflow_q)
    else $error("compute transfer did not clear the lists");

  a_done_posts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_valid && done_ready |=> out_valid_o)
    else $error("finished result was not posted");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == mosl_pkg::STATUS_EMPTY)
      |-> (out_data_o.median_doubled == '0))
    else $error("empty-list result carries a nonzero value");

endmodule

[tb/tb_median_of_two_sorted_lists.sv]
// Self-checking testbench for the median of two sorted lists block.
module tb_median_of_two_sorted_lists;
  timeunit 1ns;
  timeprecision 1ps;

  import mosl_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef logic signed [DATA_W-1:0] value_q_t[$];
  typedef enum {SPREAD_FULL, SPREAD_TINY, SPREAD_EDGES, SPREAD_NARROW} spread_e;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  // Shadow copy of the block state.
  logic signed [DATA_W-1:0] first_list [LIST_DEPTH];
  logic signed [DATA_W-1:0] second_list[LIST_DEPTH];
  int unsigned first_len;
  int unsigned second_len;
  bit          drop_seen;

  out_item_t   pending_medians[$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  median_of_two_sorted_lists u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5ns;
    clk_i = 1'b1;
    #5ns;
  end

  function automatic logic signed [DATA_W-1:0] list_entry(input bit which,
                                                          input int unsigned idx);
    if (idx >= LIST_DEPTH) begin
      return '0;
    end
    return which ? second_list[idx] : first_list[idx];
  endfunction

  // k-th smallest (k from 1) of both lists by halving; runs the same way on unsorted data.
  function automatic logic signed [DATA_W-1:0] kth_smallest(input int unsigned k_in);
    bit                       wa, wb, tw;
    int unsigned              k, sta, sza, stb, szb, ts, tz, p1, p2, guard;
    logic signed [DATA_W-1:0] x, y;
    k   = k_in;
    wa  = 1'b0;
    wb  = 1'b1;
    sta = 0;
    sza = first_len;
    stb = 0;
    szb = second_len;
    for (guard = 0; guard < 4 * LIST_DEPTH + 64; guard++) begin
      if (sza > szb) begin
        tw  = wa;
        ts  = sta;
        tz  = sza;
        wa  = wb;
        sta = stb;
        sza = szb;
        wb  = tw;
        stb = ts;
        szb = tz;
      end
      if (sza == 0 || k == 0) begin
        return list_entry(wb, stb + k - 1);
      end
      x = list_entry(wa, sta);
      y = list_entry(wb, stb);
      if (k == 1) begin
        return (x < y) ? x : y;
      end
      p1 = k / 2;
      if (p1 > sza) begin
        p1 = sza;
      end
      p2 = k - p1;
      if (p2 > szb) begin
        p2 = szb;
      end
      x = list_entry(wa, sta + p1 - 1);
      y = list_entry(wb, stb + p2 - 1);
      if (x > y) begin
        stb += p2;
        szb -= p2;
        k   -= p2;
        sza  = p1;
      end else begin
        sta += p1;
        sza -= p1;
        k   -= p1;
      end
    end
    return '0;
  endfunction

  function automatic void apply_list_item(input in_item_t item);
    out_item_t               res;
    logic signed [RES_W-1:0] lo, hi;
    int unsigned             total;
    case (item.mode)
      MODE_LOAD_FIRST: begin
        if (first_len < LIST_DEPTH) begin
          first_list[first_len] = item.value;
          first_len++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      MODE_LOAD_SECOND: begin
        if (second_len < LIST_DEPTH) begin
          second_list[second_len] = item.value;
          second_len++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      MODE_COMPUTE: begin
        total = first_len + second_len;
        if (total == 0) begin
          res.median_doubled = '0;
          res.status         = STATUS_EMPTY;
        end else begin
          if (total % 2 == 0) begin
            lo = kth_smallest(total / 2);
            hi = kth_smallest(total / 2 + 1);
          end else begin
            lo = kth_smallest(total / 2 + 1);
            hi = lo;
          end
          res.median_doubled = lo + hi;
          res.status         = drop_seen ? STATUS_OVERFLOW : STATUS_OK;
        end
        pending_medians.push_back(res);
        first_len  = 0;
        second_len = 0;
        drop_seen  = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] draw_value(input spread_e spread);
    case (spread)
      SPREAD_TINY:   return DATA_W'(int'($urandom_range(0, 16)) - 8);
      SPREAD_NARROW: return DATA_W'(int'($urandom_range(0, 2000)) - 1000);
      SPREAD_EDGES: begin
        case ($urandom_range(0, 3))
          0:       return VALUE_MIN;
          1:       return VALUE_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      default:       return $urandom;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic drive_item(input logic [1:0] mode, input logic signed [DATA_W-1:0] value);
    in_item_t item;
    item.mode  = mode;
    item.value = value;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    apply_list_item(item);
    @(negedge clk_i);
  endtask

  // Loads both lists, each in order, randomly interleaved, with optional unused-mode items.
  task automatic send_lists(input value_q_t first_vals, input value_q_t second_vals,
                            input bit with_noise);
    while (first_vals.size() + second_vals.size() != 0) begin
      if (with_noise && $urandom_range(0, 15) == 0) begin
        drive_item(MODE_UNUSED, $urandom);
      end
      if (second_vals.size() == 0 || (first_vals.size() != 0 && $urandom_range(0, 1) == 0))
      begin
        drive_item(MODE_LOAD_FIRST, first_vals.pop_front());
      end else begin
        drive_item(MODE_LOAD_SECOND, second_vals.pop_front());
      end
    end
  endtask

  task automatic test_edge_values();
    drive_item(MODE_COMPUTE, VALUE_MAX);
    drive_item(MODE_UNUSED, '1);
    drive_item(MODE_LOAD_FIRST, VALUE_MIN);
    drive_item(MODE_COMPUTE, '0);
    drive_item(MODE_LOAD_SECOND, VALUE_MAX);
    drive_item(MODE_COMPUTE, '1);
    drive_item(MODE_LOAD_FIRST, VALUE_MAX);
    drive_item(MODE_LOAD_SECOND, VALUE_MAX);
    drive_item(MODE_COMPUTE, '0);
    drive_item(MODE_LOAD_FIRST, VALUE_MIN);
    drive_item(MODE_UNUSED, VALUE_MAX);
    drive_item(MODE_LOAD_SECOND, VALUE_MIN);
    drive_item(MODE_COMPUTE, '0);
    drive_item(MODE_LOAD_FIRST, VALUE_MIN);
    drive_item(MODE_LOAD_SECOND, VALUE_MAX);
    drive_item(MODE_COMPUTE, '0);
    drive_item(MODE_LOAD_SECOND, 32'sd5);
    drive_item(MODE_LOAD_SECOND, 32'sd7);
    drive_item(MODE_COMPUTE, '0);
    drive_item(MODE_LOAD_FIRST, 32'sd1);
    drive_item(MODE_LOAD_SECOND, 32'sd2);
    drive_item(MODE_LOAD_FIRST, 32'sd3);
    drive_item(MODE_LOAD_SECOND, 32'sd4);
    drive_item(MODE_COMPUTE, '0);
  endtask

  // Fills one list past its depth, picked at random, next to a short other list.
  task automatic test_list_overflow();
    value_q_t first_vals, second_vals;
    bit       into_second;
    first_vals  = {};
    second_vals = {};
    into_second = ($urandom_range(0, 1) == 1);
    if (into_second) begin
      repeat (3) first_vals.push_back(draw_value(SPREAD_FULL));
      repeat (LIST_DEPTH + 1) second_vals.push_back(draw_value(SPREAD_FULL));
    end else begin
      repeat (LIST_DEPTH + 1) first_vals.push_back(draw_value(SPREAD_FULL));
      repeat (3) second_vals.push_back(draw_value(SPREAD_FULL));
    end
    first_vals.sort();
    second_vals.sort();
    send_lists(first_vals, second_vals, 1'b0);
    drive_item(MODE_COMPUTE, '0);
    // The drop flag was cleared by the compute above.
    drive_item(MODE_COMPUTE, '0);
  endtask

  task automatic test_random_lists(input int unsigned n_items);
    value_q_t    first_vals, second_vals;
    int unsigned sent, len_first, len_second;
    spread_e     spread;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        len_first  = $urandom_range(0, 40);
        len_second = $urandom_range(0, 40);
      end else begin
        len_first  = $urandom_range(0, 8);
        len_second = $urandom_range(0, 8);
      end
      spread      = spread_e'($urandom_range(0, 3));
      first_vals  = {};
      second_vals = {};
      repeat (len_first) first_vals.push_back(draw_value(spread));
      repeat (len_second) second_vals.push_back(draw_value(spread));
      // Most sets are well formed; the rest keep their random order.
      if ($urandom_range(0, 11) != 0) begin
        first_vals.sort();
        second_vals.sort();
      end
      send_lists(first_vals, second_vals, 1'b1);
      sent += len_first + len_second;
      // An occasional set runs on into the next one without a compute.
      if ($urandom_range(0, 14) != 0) begin
        drive_item(MODE_COMPUTE, $urandom);
        sent++;
      end
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_medians.size() == 0) begin
        $display("%0t: unexpected result, median_doubled %0d status %0d", $time,
                 out_data_o.median_doubled, out_data_o.status);
        mismatches++;
      end else begin
        want = pending_medians.pop_front();
        if (out_data_o.median_doubled !== want.median_doubled) begin
          $display("%0t: median_doubled expected %0d, got %0d", $time,
                   want.median_doubled, out_data_o.median_doubled);
          mismatches++;
        end
        if (out_data_o.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status,
                   out_data_o.status);
          mismatches++;
        end
      end
    end
  end

  // Ends the run when no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b0;
    first_len      = 0;
    second_len     = 0;
    drop_seen      = 1'b0;
    mismatches     = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 29;
    recv_stall_pct = 80;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_edge_values();
    test_random_lists(50);

    send_idle_pct  = 80;
    recv_stall_pct = 29;
    test_list_overflow();
    test_random_lists(50);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_lists(50);

    in_valid_i <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_medians.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
